### hw/rtl/mie_pkg.sv
// Package for the modular inverse block: word width, counter width and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none

package mie_pkg;

    // Width of the fields on the ports
    localparam int FIELD_BITS = 32;
    // Internal arithmetic width; port fields are masked or extended to it
    localparam int WORD_BITS  = 32;
    // Shift counter width for the divide alignment (holds 0..WORD_BITS-1)
    localparam int CNT_W      = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;     // capture a new word, start Euclid
        logic start_div;   // set up divisor and remainder for one quotient step
        logic align_shift; // shift divisor left one place
        logic div_step;    // one restoring divide bit
        logic update;      // rotate remainders and coefficients
        logic reduce;      // bring coefficient below the modulus
        logic load_out;    // write the result register
    } mie_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic rb_zero;     // current divisor is zero: Euclid done
        logic align_more;  // divisor can still be doubled
        logic cnt_zero;    // last divide bit
    } mie_status_t;

endpackage

`default_nettype wire

### hw/rtl/mie_datapath.sv
// Datapath of the modular inverse: remainders, coefficient magnitudes, a
// shift-subtract divider that builds q*cb on the fly, and the result register.
// Depends on mie_pkg.
`default_nettype none

module mie_datapath
    import mie_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire mie_cmd_t              cmd,
    output mie_status_t                status,
    input  wire logic [FIELD_BITS-1:0] modulus,
    input  wire logic [FIELD_BITS-1:0] value,
    output logic [FIELD_BITS-1:0]      inverse,
    output logic [FIELD_BITS-1:0]      common_divisor,
    output logic                       invertible
);

    word_t m_reg, ra_reg, rb_reg, ca_reg, cb_reg;
    logic  nega_reg;
    word_t d_reg, rem_reg, acc_reg;
    cnt_t  cnt_reg;
    logic [FIELD_BITS-1:0] inv_reg, gcd_reg;
    logic  ok_reg;

    // Divider helpers
    word_t d_shl;
    logic  ge;
    word_t rem_sub;
    word_t acc_add;
    word_t acc_shl;

    // Result helpers
    logic  ok_now;
    word_t inv_now;

    assign d_shl   = {d_reg[WORD_BITS-2:0], 1'b0};
    assign ge      = (rem_reg >= d_reg);
    assign rem_sub = rem_reg - d_reg;
    assign acc_shl = {acc_reg[WORD_BITS-2:0], 1'b0};
    assign acc_add = acc_shl + (ge ? cb_reg : '0);

    assign ok_now  = (ra_reg == word_t'(1)) && (m_reg != '0);
    always_comb
    begin
        inv_now = '0;
        if (ok_now)
        begin
            inv_now = (nega_reg && (ca_reg != '0)) ? (m_reg - ca_reg) : ca_reg;
        end
    end

    // Status back to the controller
    assign status.rb_zero    = (rb_reg == '0);
    assign status.align_more = !d_reg[WORD_BITS-1] && (d_shl <= rem_reg);
    assign status.cnt_zero   = (cnt_reg == '0);

    // Euclid registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            m_reg    <= word_t'(modulus);
            ra_reg   <= word_t'(modulus);
            rb_reg   <= word_t'(value);
            ca_reg   <= '0;
            cb_reg   <= word_t'(1);
            nega_reg <= 1'b1;
        end
        else if (cmd.update)
        begin
            ra_reg   <= rb_reg;
            rb_reg   <= rem_reg;
            ca_reg   <= cb_reg;
            cb_reg   <= acc_reg + ca_reg;
            nega_reg <= !nega_reg;
        end
        else if (cmd.reduce)
        begin
            // ca never exceeds the modulus, so one subtract suffices
            if (ca_reg >= m_reg)
            begin
                ca_reg <= ca_reg - m_reg;
            end
        end
    end

    // Divider: align divisor under the remainder, then one bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.start_div)
        begin
            d_reg   <= rb_reg;
            rem_reg <= ra_reg;
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else if (cmd.align_shift)
        begin
            d_reg   <= d_shl;
            cnt_reg <= cnt_reg + cnt_t'(1);
        end
        else if (cmd.div_step)
        begin
            if (ge)
            begin
                rem_reg <= rem_sub;
            end
            acc_reg <= acc_add;
            d_reg   <= d_reg >> 1;
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - cnt_t'(1);
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            inv_reg <= FIELD_BITS'(inv_now);
            gcd_reg <= FIELD_BITS'(ra_reg);
            ok_reg  <= ok_now;
        end
    end

    assign inverse        = inv_reg;
    assign common_divisor = gcd_reg;
    assign invertible     = ok_reg;

    // New remainder is below the new divisor after each step
    a_rem_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.update) |-> (rb_reg < ra_reg))
        else $error("remainder not below divisor after update");

    // Coefficient magnitude stays within the modulus
    a_coef_bound: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.update) |-> (cb_reg <= m_reg))
        else $error("coefficient magnitude above modulus");

    // Reduced coefficient lies below a nonzero modulus
    a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        $past(cmd.reduce) |-> ((ca_reg < m_reg) || (m_reg == '0)))
        else $error("coefficient not reduced");

endmodule

`default_nettype wire

### hw/rtl/mie_ctrl.sv
// Controller of the modular inverse: sequences Euclid steps, the divider
// align/divide phases and the output handshake. Depends on mie_pkg.
`default_nettype none

module mie_ctrl
    import mie_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire mie_status_t status,
    output mie_cmd_t         cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_ALIGN,
        S_DIVIDE,
        S_UPDATE,
        S_REDUCE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   in_take;
    logic   out_free;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // Commands and next state
    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (status.rb_zero)
                begin
                    state_next = S_REDUCE;
                end
                else
                begin
                    cmd.start_div = 1'b1;
                    state_next    = S_ALIGN;
                end
            end
            S_ALIGN:
            begin
                if (status.align_more)
                begin
                    cmd.align_shift = 1'b1;
                end
                else
                begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (status.cnt_zero)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = S_CHECK;
            end
            S_REDUCE:
            begin
                cmd.reduce = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Result register is never overwritten while a word waits
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !cmd.load_out)
        else $error("result overwritten while stalled");

    // Each divide pass ends in one coefficient update
    a_div_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && status.cnt_zero) |=> cmd.update)
        else $error("divide pass not followed by update");

endmodule

`default_nettype wire

### hw/rtl/modular_inverse_ext_euclid.sv
// Each word runs N Euclid quotient steps, each with a divisor alignment shift
// k_i and one restoring divide pass (sum of k_i is at most about WORD_BITS);
// a zero value goes straight to the reduce and finish states. The longest run
// at 32 bits comes from consecutive Fibonacci operands.
// Throughput: one word at a time, set by the shared shift-subtract divider;
// the next word is taken while the previous result still waits.
// Reset: rst_n asynchronous active low, clears controller and output valid.
`default_nettype none

module modular_inverse_ext_euclid
    import mie_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [FIELD_BITS-1:0] modulus,
    input  wire logic [FIELD_BITS-1:0] value,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [FIELD_BITS-1:0]      inverse,
    output logic [FIELD_BITS-1:0]      common_divisor,
    output logic                       invertible
);

    mie_cmd_t    cmd;
    mie_status_t status;

    // Sequencer
    mie_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // Arithmetic and result register
    mie_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .modulus        (modulus),
        .value          (value),
        .inverse        (inverse),
        .common_divisor (common_divisor),
        .invertible     (invertible)
    );

endmodule

`default_nettype wire
